@@ hw/rtl/class_priority_request_queue_assert.svh @@
// Assertion macros for the class priority request queue.
// Needs signals clk and rst_n in the module that uses the macros.
`ifndef CLASS_PRIORITY_REQUEST_QUEUE_ASSERT_SVH
`define CLASS_PRIORITY_REQUEST_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CPRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPRQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/cprq_pkg.sv @@
// Shared types and constants for the class priority request queue.
// No dependencies; used by cprq_ctrl, cprq_dpath and the top level.
package cprq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int TAG_BITS  = 16;
  localparam int POL_W     = 2;
  localparam int CAP_W     = 5;
  localparam int OCC_W     = 5;

  localparam logic [POL_W-1:0] POL_FIFO    = 2'd0;
  localparam logic [POL_W-1:0] POL_STATIC  = 2'd1;
  localparam logic [POL_W-1:0] POL_DYNAMIC = 2'd2;
  localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;

  // register indexes (paddr[2])
  localparam logic REG_POLICY   = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  // request kinds
  localparam logic REQ_INSERT   = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REJECT,
    OP_DISPATCH,
    OP_EMPTY
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic                req_type;
    logic [TAG_BITS-1:0] tag;
    logic                req_static;
  } in_item_t;

  typedef struct packed {
    stat_t               status;
    logic [TAG_BITS-1:0] out_tag;
    logic                out_static;
    logic [OCC_W-1:0]    occupancy;
  } out_item_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

@@ hw/rtl/class_priority_request_queue.sv @@
// Class priority request queue, top level: config registers, controller, datapath.
// The result strobe (out_valid) is high for one cycle; it is registered at the end of the execute state.
// A new item is not taken while busy; busy is high for the execute cycle after each accept.
// The execute cycle does find-first, compaction and the tail write of the entry store.
// Reset (rst_n low, synchronous): queue empty, policy FIFO, capacity 16; entries undefined.
// Results cannot be held off by the receiver.
module class_priority_request_queue #(
  parameter int DEPTH = cprq_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  cprq_pkg::in_item_t   in_data,
  // result channel
  output logic                 out_valid,
  output cprq_pkg::out_item_t  out_data,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import cprq_pkg::*;

  logic [POL_W-1:0] policy_r;
  logic [CAP_W-1:0] capacity_r;
  logic             cfg_wr;
  cmd_t             cmd;
  dp_stat_t         dp_stat;

  // Register map: policy at byte 0, capacity at byte 4; paddr[2] picks the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= POL_FIFO;
      capacity_r <= CAP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_POLICY) begin
        policy_r <= pwdata[POL_W-1:0];
      end else begin
        capacity_r <= pwdata[CAP_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_r) : 32'(policy_r);

  // Controller: takes an item when idle, then issues one operation to the datapath,
  // chosen from the request kind and the empty/full flags.
  cprq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_data.req_type),
    .dp_stat  (dp_stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Datapath: entry store kept in arrival order; a dispatch pulls the picked entry
  // and shifts all younger entries down in the same cycle.
  cprq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .policy    (policy_r),
    .capacity  (capacity_r),
    .dp_stat   (dp_stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/cprq_ctrl.sv @@
// Controller for the class priority request queue: accept/execute sequencing.
// Depends on cprq_pkg and class_priority_request_queue_assert.svh.
`include "class_priority_request_queue_assert.svh"

module cprq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               req_type,
  input  cprq_pkg::dp_stat_t dp_stat,
  output logic               busy,
  output cprq_pkg::cmd_t     cmd
);
  import cprq_pkg::*;

  state_t state_r, state_nxt;
  logic   req_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= req_type;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.op   = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_EXEC: begin
        busy = 1'b1;
        if (req_type_r == REQ_DISPATCH) begin
          cmd.op = dp_stat.empty ? OP_EMPTY : OP_DISPATCH;
        end else begin
          cmd.op = dp_stat.full ? OP_REJECT : OP_INSERT;
        end
      end
    endcase
  end

  `CPRQ_ASSERT_NXT(a_load_exec, cmd.load, state_r == S_EXEC, "accept not followed by execute")
  `CPRQ_ASSERT_NXT(a_exec_once, state_r == S_EXEC, state_r == S_IDLE, "execute held too long")
  `CPRQ_ASSERT_IMP(a_exec_op, state_r == S_EXEC, cmd.op != OP_NONE && !cmd.load,
                   "execute cycle without operation")

endmodule

@@ hw/rtl/cprq_dpath.sv @@
// Datapath: entry store with find-first select, compaction on dispatch, result register.
// Depends on cprq_pkg and class_priority_request_queue_assert.svh.
`include "class_priority_request_queue_assert.svh"

module cprq_dpath #(
  parameter int DEPTH = cprq_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cprq_pkg::cmd_t                 cmd,
  input  cprq_pkg::in_item_t             in_data,
  input  logic [cprq_pkg::POL_W-1:0]     policy,
  input  logic [cprq_pkg::CAP_W-1:0]     capacity,
  output cprq_pkg::dp_stat_t             dp_stat,
  output logic                           out_valid,
  output cprq_pkg::out_item_t            out_data
);
  import cprq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [TAG_BITS-1:0] tag_r [DEPTH];
  logic [DEPTH-1:0]    cls_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TAG_BITS-1:0] tag_in_r;
  logic                cls_in_r;
  out_item_t           res_r, res_nxt;
  logic                out_valid_r;

  logic [DEPTH-1:0]    occ, match, first, pick, ge_mask;
  logic                pol_sel, want_cls;
  logic [TAG_BITS-1:0] sel_tag;
  logic                sel_cls;

  // live entries sit below count
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (CNT_W'(i) < count_r);
    end
  end

  assign pol_sel  = (policy == POL_STATIC) || (policy == POL_DYNAMIC);
  assign want_cls = (policy == POL_STATIC);

  // oldest entry of wanted class, else head
  always_comb begin
    match   = pol_sel ? (occ & (want_cls ? cls_r : ~cls_r)) : '0;
    first   = match & (~match + DEPTH'(1));
    pick    = (match == '0) ? DEPTH'(1) : first;
    ge_mask = ~(pick - DEPTH'(1));
    sel_tag = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pick[i]) sel_tag = sel_tag | tag_r[i];
    end
    sel_cls = |(pick & cls_r);
  end

  assign dp_stat.empty = (count_r == '0);
  assign dp_stat.full  = (32'(count_r) >= 32'(capacity)) || (32'(count_r) >= DEPTH);

  always_comb begin
    count_nxt          = count_r;
    res_nxt.status     = ST_DONE;
    res_nxt.out_tag    = '0;
    res_nxt.out_static = 1'b0;
    unique case (cmd.op)
      OP_INSERT:   count_nxt = count_r + CNT_W'(1);
      OP_DISPATCH: begin
        count_nxt          = count_r - CNT_W'(1);
        res_nxt.out_tag    = sel_tag;
        res_nxt.out_static = sel_cls;
      end
      OP_REJECT:   res_nxt.status = ST_FULL;
      OP_EMPTY:    res_nxt.status = ST_EMPTY;
      OP_NONE:     ;
    endcase
    res_nxt.occupancy = OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= (cmd.op != OP_NONE);
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_in_r <= in_data.tag;
      cls_in_r <= in_data.req_static;
    end
    if (cmd.op != OP_NONE) begin
      res_r <= res_nxt;
    end
    if (cmd.op == OP_INSERT) begin
      tag_r[count_r[IDX_W-1:0]] <= tag_in_r;
      cls_r[count_r[IDX_W-1:0]] <= cls_in_r;
    end else if (cmd.op == OP_DISPATCH) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (ge_mask[i]) begin
          tag_r[i] <= tag_r[i+1];
          cls_r[i] <= cls_r[i+1];
        end
      end
      if (ge_mask[DEPTH-1]) begin
        tag_r[DEPTH-1] <= '0;
        cls_r[DEPTH-1] <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  `CPRQ_ASSERT_IMP(a_cnt_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `CPRQ_ASSERT_NXT(a_res_strobe, cmd.op != OP_NONE, out_valid_r, "missing result strobe")
  `CPRQ_ASSERT_NXT(a_fail_hold, cmd.op == OP_REJECT || cmd.op == OP_EMPTY, $stable(count_r),
                   "failed item changed count")
  `CPRQ_ASSERT_NXT(a_disp_dec, cmd.op == OP_DISPATCH, count_r + CNT_W'(1) == $past(count_r),
                   "dispatch did not remove one entry")

endmodule
